// ----- rtl/core/dadf_pkg.sv -----
package dadf_pkg;

    // Input dimension field width and the number of codes it can carry
    localparam int DIM_W = 6;
    localparam int DIM_CODES = 1 << DIM_W;

    // Per-dimension history: four most recent samples, newest first
    localparam int HIST_DEPTH = 4;

    // Frame counter saturates at the history depth
    localparam int CNT_W = 3;
    typedef logic [CNT_W-1:0] t_count;
    localparam t_count CNT_MAX = 3'd4;

    // Up to three results per input transaction (flush on the last frame)
    localparam int MAX_RES = 3;
    typedef logic [1:0] t_nres;

    // Control handed from the delta datapath to the output buffer
    typedef struct packed {
        t_nres num;      // number of results in this bundle
        logic  seq_end;  // final result of the bundle closes the sequence
    } t_emit;

endpackage

// ----- rtl/core/dadf_ram.sv -----
module dadf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read that holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dadf_calc.sv -----
module dadf_calc #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                         i_enable,
    input  logic signed [SAMPLE_BITS-1:0]                i_sample,
    input  logic                                         i_first,
    input  logic                                         i_last,
    input  dadf_pkg::t_count                             i_count,
    input  logic [dadf_pkg::HIST_DEPTH*SAMPLE_BITS-1:0]  i_hist,
    output dadf_pkg::t_emit                              o_emit,
    output logic signed [SAMPLE_BITS-1:0]                o_static [dadf_pkg::MAX_RES],
    output logic signed [SAMPLE_BITS:0]                  o_delta  [dadf_pkg::MAX_RES],
    output logic signed [SAMPLE_BITS+1:0]                o_accel  [dadf_pkg::MAX_RES],
    output dadf_pkg::t_count                             o_count,
    output logic [dadf_pkg::HIST_DEPTH*SAMPLE_BITS-1:0]  o_hist
);

    import dadf_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int EW = SAMPLE_BITS + 3;

    t_count                c;
    logic signed [SB-1:0]  w [HIST_DEPTH+1];
    logic signed [EW-1:0]  e [HIST_DEPTH+1];
    logic signed [EW-1:0]  d1, d2, d3, d4;
    logic signed [EW-1:0]  a2, a3, a4;
    logic signed [SB-1:0]  sv [MAX_RES];
    logic signed [EW-1:0]  dv [MAX_RES];
    logic signed [EW-1:0]  av [MAX_RES];
    logic [1:0]            sel;
    logic [2:0]            idx;

    // Effective frame count: a first mark restarts, stored counts saturate
    assign c = i_first ? '0 : ((i_count > CNT_MAX) ? CNT_MAX : i_count);

    // Window: positions 0..3 are history (oldest first), position 4 is the new sample
    always_comb begin
        w[HIST_DEPTH] = i_sample;
        for (int j = 0; j < HIST_DEPTH; j++) begin
            w[HIST_DEPTH-1-j] = i_hist[j*SB +: SB];
        end
        for (int p = 0; p <= HIST_DEPTH; p++) begin
            e[p] = EW'(w[p]);
        end
    end

    // Deltas at window positions; the first frame of a sequence sits at position 4-c
    assign d1 = (c == 3'd3) ? (e[2] - e[1]) : ((e[2] - e[0]) >>> 1);
    assign d2 = (c == 3'd2) ? (e[3] - e[2]) : ((e[3] - e[1]) >>> 1);
    assign d3 = (c == 3'd1) ? (e[4] - e[3]) : ((e[4] - e[2]) >>> 1);
    assign d4 = e[4] - e[3];

    // Delta-deltas; position 4 is only emitted on the last frame
    assign a2 = (c == 3'd2) ? (d3 - d2) : ((d3 - d1) >>> 1);
    assign a3 = (c == 3'd1) ? (d4 - d3) : ((d4 - d2) >>> 1);
    assign a4 = d4 - d3;

    // Candidate results at positions 2, 3 and 4; a lone frame has zero deltas
    always_comb begin
        sv[0] = w[2];
        sv[1] = w[3];
        sv[2] = w[4];
        dv[0] = d2;
        dv[1] = d3;
        dv[2] = (c == '0) ? '0 : d4;
        av[0] = a2;
        av[1] = a3;
        av[2] = (c == '0) ? '0 : a4;
    end

    // Flush starts at the oldest pending frame, otherwise position 2 is emitted
    always_comb begin
        if (i_last && c < 3'd2) begin
            sel = 2'(3'd2 - c);
        end else begin
            sel = 2'd0;
        end
    end

    // Bundle assembly, count and history update
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            idx = 3'(k) + 3'(sel);
            if (idx < 3'(MAX_RES)) begin
                o_static[k] = sv[idx[1:0]];
                o_delta[k]  = dv[idx[1:0]][SB:0];
                o_accel[k]  = av[idx[1:0]][SB+1:0];
            end else begin
                o_static[k] = '0;
                o_delta[k]  = '0;
                o_accel[k]  = '0;
            end
        end
        o_hist = i_hist;
        o_emit.seq_end = i_last;
        if (!i_enable) begin
            o_emit.num  = 2'd1;
            o_static[0] = i_sample;
            o_delta[0]  = '0;
            o_accel[0]  = '0;
            o_count     = '0;
        end else if (i_last) begin
            o_emit.num = (c >= 3'd2) ? 2'd3 : 2'(c + 3'd1);
            o_count    = '0;
        end else begin
            o_emit.num = (c >= 3'd2) ? 2'd1 : 2'd0;
            o_count    = (c == CNT_MAX) ? CNT_MAX : c + 3'd1;
            o_hist     = {i_hist[(HIST_DEPTH-1)*SB-1:0], i_sample};
        end
    end

endmodule

// ----- rtl/core/dadf_obuf.sv -----
module dadf_obuf #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  dadf_pkg::t_emit                     i_emit,
    input  logic [dadf_pkg::DIM_W-1:0]          i_dim,
    input  logic signed [SAMPLE_BITS-1:0]       i_static [dadf_pkg::MAX_RES],
    input  logic signed [SAMPLE_BITS:0]         i_delta  [dadf_pkg::MAX_RES],
    input  logic signed [SAMPLE_BITS+1:0]       i_accel  [dadf_pkg::MAX_RES],
    output logic                                o_can_load,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dadf_pkg::DIM_W-1:0]          o_dim,
    output logic signed [SAMPLE_BITS-1:0]       o_static,
    output logic signed [SAMPLE_BITS:0]         o_delta,
    output logic signed [SAMPLE_BITS+1:0]       o_accel,
    output logic                                o_last,
    output logic                                o_seq_end
);

    import dadf_pkg::*;

    t_nres                         r_cnt;
    t_nres                         n_cnt;
    logic                          r_seq_end;
    logic [DIM_W-1:0]              r_dim;
    logic signed [SAMPLE_BITS-1:0] r_static [MAX_RES];
    logic signed [SAMPLE_BITS:0]   r_delta  [MAX_RES];
    logic signed [SAMPLE_BITS+1:0] r_accel  [MAX_RES];
    logic                          take;

    assign take       = (r_cnt != '0) && i_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == 2'd1) && i_ready);

    // Pending result count
    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_emit.num;
        end else if (take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Result entries: load a whole bundle, shift toward entry 0 on each transaction
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seq_end <= i_emit.seq_end;
            r_dim     <= i_dim;
            for (int k = 0; k < MAX_RES; k++) begin
                r_static[k] <= i_static[k];
                r_delta[k]  <= i_delta[k];
                r_accel[k]  <= i_accel[k];
            end
        end else if (take) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_static[k] <= r_static[k+1];
                r_delta[k]  <= r_delta[k+1];
                r_accel[k]  <= r_accel[k+1];
            end
        end
    end

    assign o_valid   = (r_cnt != '0);
    assign o_dim     = r_dim;
    assign o_static  = r_static[0];
    assign o_delta   = r_delta[0];
    assign o_accel   = r_accel[0];
    assign o_last    = (r_cnt == 2'd1);
    assign o_seq_end = r_seq_end && (r_cnt == 2'd1);

endmodule

// ----- rtl/core/delta_and_acceleration_features_unit.sv -----
// Delta and delta-delta feature unit.
// Slave stream: one feature sample per transaction. tdata carries the dimension
// index and the signed sample, tuser marks the first frame of a sequence and
// tlast the last frame. Master stream: tdata carries dimension, static value,
// delta and delta-delta; tlast marks the final result caused by one input,
// tuser marks the result that is the last frame of the sequence.
// Each frame is emitted two frames late; the last frame flushes up to three
// results. With deltas disabled (cfg write of 0) every sample passes through
// at once with zero deltas.
// An input is registered in the input stage, and its results are then loaded
// into the output buffer. Throughput is one input per cycle while the output
// buffer can take each bundle; an input that causes k results occupies the
// output buffer until all k are taken. The per-dimension read-modify-write
// of the history RAM is closed by a one-entry write-back forward.
// Reset: the frame-count RAM is swept to zero, one dimension per cycle, so
// tready stays low after reset until the sweep ends; cfg writes are taken.
// A stalled master side holds the current result and stalls the slave side
// only once both the output buffer and the input stage are full.
module delta_and_acceleration_features_unit #(
    parameter int NUM_DIMS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // cfg: enable_deltas
    input  logic i_cfg_we,
    input  logic [0:0] i_cfg_wdata,
    // slave stream
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata: dim_index, sample
    input  logic [((dadf_pkg::DIM_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // tuser: first_frame
    input  logic i_s_axis_tuser,
    // tlast: last_frame
    input  logic i_s_axis_tlast,
    // master stream
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // tdata: out_dim, static_value, delta_value, accel_value
    output logic [((dadf_pkg::DIM_W + 3 * SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // tuser: sequence_end
    output logic o_m_axis_tuser,
    // tlast: run_last
    output logic o_m_axis_tlast
);

    import dadf_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
    localparam int HW     = HIST_DEPTH * SAMPLE_BITS;
    localparam int OUT_DW = ((DIM_W + 3 * SAMPLE_BITS + 3 + 7) / 8) * 8;

    logic [AW-1:0]        slot_tab [DIM_CODES];
    logic [DIM_W-1:0]     in_dim;
    logic [AW-1:0]        in_slot;
    logic                 s_accept;
    logic                 s1_fire;
    logic                 ob_load;
    logic                 ob_can_load;

    logic                 r_enable;
    logic                 r_clearing;
    logic [AW-1:0]        r_clr_addr;
    logic                 r_s1_valid;
    logic [DIM_W-1:0]     r_dim;
    logic [AW-1:0]        r_slot;
    logic signed [SB-1:0] r_sample;
    logic                 r_first;
    logic                 r_last;
    logic                 r_fw_valid;
    logic [AW-1:0]        r_fw_slot;
    t_count               r_fw_count;
    logic [HW-1:0]        r_fw_hist;

    t_count               ram_count;
    logic [HW-1:0]        ram_hist;
    t_count               cur_count;
    logic [HW-1:0]        cur_hist;
    logic                 fw_hit;
    logic                 cnt_we;
    logic [AW-1:0]        cnt_waddr;
    t_count               cnt_wdata;

    t_emit                calc_emit;
    logic signed [SB-1:0] calc_static [MAX_RES];
    logic signed [SB:0]   calc_delta  [MAX_RES];
    logic signed [SB+1:0] calc_accel  [MAX_RES];
    t_count               calc_count;
    logic [HW-1:0]        calc_hist;

    logic [DIM_W-1:0]     ob_dim;
    logic signed [SB-1:0] ob_static;
    logic signed [SB:0]   ob_delta;
    logic signed [SB+1:0] ob_accel;

    // Dimension to RAM slot, reduced modulo NUM_DIMS by a constant table
    for (genvar g = 0; g < DIM_CODES; g++) begin : g_slot
        assign slot_tab[g] = AW'(g % NUM_DIMS);
    end

    assign in_dim  = i_s_axis_tdata[DIM_W-1:0];
    assign in_slot = slot_tab[in_dim];

    // Handshake: the input stage advances when its bundle can move on
    assign s1_fire         = r_s1_valid && ((calc_emit.num == '0) || ob_can_load);
    assign ob_load         = s1_fire && (calc_emit.num != '0);
    assign o_s_axis_tready = !r_clearing && (!r_s1_valid || s1_fire);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata[0];
        end
    end

    // Post-reset sweep of the frame-count RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(NUM_DIMS - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_dim    <= in_dim;
            r_slot   <= in_slot;
            r_sample <= i_s_axis_tdata[DIM_W +: SB];
            r_first  <= i_s_axis_tuser;
            r_last   <= i_s_axis_tlast;
        end
    end

    // Write-back forward covers a read issued in the same cycle as the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (s1_fire) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_fw_slot  <= r_slot;
            r_fw_count <= calc_count;
            r_fw_hist  <= calc_hist;
        end
    end

    assign fw_hit    = r_fw_valid && (r_fw_slot == r_slot);
    assign cur_count = fw_hit ? r_fw_count : ram_count;
    assign cur_hist  = fw_hit ? r_fw_hist : ram_hist;

    // Frame-count RAM: sweep writes zero, otherwise the updated count
    assign cnt_we    = r_clearing || s1_fire;
    assign cnt_waddr = r_clearing ? r_clr_addr : r_slot;
    assign cnt_wdata = r_clearing ? '0 : calc_count;

    dadf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_DIMS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (s_accept),
        .i_raddr (in_slot),
        .o_rdata (ram_count)
    );

    dadf_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_DIMS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_slot),
        .i_wdata (calc_hist),
        .i_re    (s_accept),
        .i_raddr (in_slot),
        .o_rdata (ram_hist)
    );

    // Delta and delta-delta datapath
    dadf_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calc (
        .i_enable (r_enable),
        .i_sample (r_sample),
        .i_first  (r_first),
        .i_last   (r_last),
        .i_count  (cur_count),
        .i_hist   (cur_hist),
        .o_emit   (calc_emit),
        .o_static (calc_static),
        .o_delta  (calc_delta),
        .o_accel  (calc_accel),
        .o_count  (calc_count),
        .o_hist   (calc_hist)
    );

    // Result bundle buffer
    dadf_obuf #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ob_load),
        .i_emit     (calc_emit),
        .i_dim      (r_dim),
        .i_static   (calc_static),
        .i_delta    (calc_delta),
        .i_accel    (calc_accel),
        .o_can_load (ob_can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_dim      (ob_dim),
        .o_static   (ob_static),
        .o_delta    (ob_delta),
        .o_accel    (ob_accel),
        .o_last     (o_m_axis_tlast),
        .o_seq_end  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = OUT_DW'({ob_accel, ob_delta, ob_static, ob_dim});

endmodule

// ----- rtl/core/dadf_checker.sv -----
module dadf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_s_axis_tready,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((dadf_pkg::DIM_W + 3 * SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    input logic o_m_axis_tuser,
    input logic o_m_axis_tlast
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("master tvalid dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("master payload changed while stalled");

    // The sequence's final frame is always the final result of its input
    a_seq_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("sequence end without run last");

    // After reset the count RAM sweep blocks input and no result is pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("activity right after reset");

endmodule

bind delta_and_acceleration_features_unit dadf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_dadf_checker (.*);

// ----- dv/tb_delta_and_acceleration_features_unit.sv -----
`timescale 1ns / 1ps

module tb_delta_and_acceleration_features_unit;

    import dadf_pkg::*;

    localparam int N_DIMS     = 64;
    localparam int SMP_W      = 16;
    localparam int LAT_PAD    = 8;      // cycles allowed past the pipeline latency
    localparam int LONG_STALL = 300;    // sink hold-off for the backpressure test
    localparam int DRAIN_MAX  = 20000;

    // One result as seen on the master side
    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic [15:0]      stat;
        logic [16:0]      delt;
        logic [17:0]      acc;
        logic             rl;
        logic             se;
    } t_feat;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Shadow state of the block
    bit          dlt_en;
    longint      hist [0:N_DIMS-1][0:HIST_DEPTH-1];
    int          cnt [0:N_DIMS-1];
    longint      fwin [0:4];        // fwin[p] is virtual frame c - 4 + p
    t_feat       pending_feats [$];

    int          mism = 0;
    bit          no_idle = 1'b0;
    int          stall_asks = 0;
    int          stall_served = 0;

    delta_and_acceleration_features_unit #(
        .NUM_DIMS   (N_DIMS),
        .SAMPLE_BITS(SMP_W)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),     // dim_index, sample
        .i_s_axis_tuser (s_tuser),     // first_frame
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),     // out_dim, static_value, delta_value, accel_value
        .o_m_axis_tuser (m_tuser),     // sequence_end
        .o_m_axis_tlast (m_tlast)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // Feature predictor
    // ---------------------------------------------------------------
    function automatic longint win_x(input int c, input int v);
        int p = v - c + 4;
        if (p < 0 || p > 4) return 0;
        return fwin[p];
    endfunction

    function automatic longint slope(input int c, input int v, input bit lf);
        if (lf && c == 0) return 0;
        if (v == 0) return win_x(c, 1) - win_x(c, 0);
        if (lf && v == c) return win_x(c, c) - win_x(c, c - 1);
        return (win_x(c, v + 1) - win_x(c, v - 1)) >>> 1;
    endfunction

    function automatic longint curve(input int c, input int v, input bit lf);
        if (lf && c == 0) return 0;
        if (v == 0) return slope(c, 1, lf) - slope(c, 0, lf);
        if (lf && v == c) return slope(c, c, lf) - slope(c, c - 1, lf);
        return (slope(c, v + 1, lf) - slope(c, v - 1, lf)) >>> 1;
    endfunction

    function automatic void add_feat(input logic [5:0] dim, input longint s, input longint d,
                                     input longint a, input bit rl, input bit se);
        t_feat f;
        f.dim  = dim;
        f.stat = s[15:0];
        f.delt = d[16:0];
        f.acc  = a[17:0];
        f.rl   = rl;
        f.se   = se;
        pending_feats = {pending_feats, f};
    endfunction

    function automatic void predict_features(input logic [5:0] dim, input logic [15:0] smp,
                                             input logic ff, input logic lf);
        longint x;
        int     c;
        int     v;
        x = longint'($signed(smp));
        // passthrough mode clears the dimension's count
        if (!dlt_en) begin
            cnt[dim] = 0;
            add_feat(dim, x, 0, 0, 1'b1, lf);
            return;
        end
        if (ff) cnt[dim] = 0;
        c = cnt[dim];
        fwin[4] = x;
        for (int j = 0; j < HIST_DEPTH; j++) fwin[3-j] = hist[dim][j];
        // last frame flushes up to three pending frames
        if (lf) begin
            for (v = (c >= 2) ? c - 2 : 0; v <= c; v++)
                add_feat(dim, win_x(c, v), slope(c, v, 1'b1), curve(c, v, 1'b1),
                         v == c, v == c);
            cnt[dim] = 0;
            return;
        end
        if (c >= 2)
            add_feat(dim, win_x(c, c - 2), slope(c, c - 2, 1'b0), curve(c, c - 2, 1'b0),
                     1'b1, 1'b0);
        for (int j = HIST_DEPTH - 1; j > 0; j--) hist[dim][j] = hist[dim][j-1];
        hist[dim][0] = x;
        cnt[dim] = (c < 4) ? c + 1 : 4;
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_feat got;
        t_feat want;
        if (rst_n && m_tvalid && m_tready) begin
            got.dim  = m_tdata[5:0];
            got.stat = m_tdata[21:6];
            got.delt = m_tdata[38:22];
            got.acc  = m_tdata[56:39];
            got.rl   = m_tlast;
            got.se   = m_tuser;
            if (pending_feats.size() == 0) begin
                mism++;
                $display("%0t unexpected result: dim=%0d s=%h d=%h a=%h last=%b end=%b",
                         $time, got.dim, got.stat, got.delt, got.acc, got.rl, got.se);
            end else begin
                want = pending_feats.pop_front();
                if (got.dim !== want.dim || got.stat !== want.stat ||
                    got.delt !== want.delt || got.acc !== want.acc ||
                    got.rl !== want.rl || got.se !== want.se) begin
                    mism++;
                    $display("%0t mismatch: expected dim=%0d s=%h d=%h a=%h last=%b end=%b",
                             $time, want.dim, want.stat, want.delt, want.acc, want.rl, want.se);
                    $display("%0t           actual   dim=%0d s=%h d=%h a=%h last=%b end=%b",
                             $time, got.dim, got.stat, got.delt, got.acc, got.rl, got.se);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sink pacing: random idle bursts, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge clk);
            if (stall_served != stall_asks) begin
                m_tready <= 1'b0;
                for (int n = 0; n < LONG_STALL; n++) @(posedge clk);
                stall_served++;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_sample(input logic [5:0] dim, input logic [15:0] smp,
                               input logic ff, input logic lf);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, smp, dim};
        s_tuser  <= ff;
        s_tlast  <= lf;
        do @(posedge clk); while (!s_tready);
        predict_features(dim, smp, ff, lf);
    endtask

    // wait until the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_feats.size() != 0) @(posedge clk);
        repeat (LAT_PAD) @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        dlt_en = v;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_single_frame();
        push_sample(6'd0,  16'h7fff, 1'b1, 1'b1);
        push_sample(6'd63, 16'h8000, 1'b1, 1'b1);
    endtask

    task automatic test_short_sequences();
        // two frames: full-scale swing on both ends
        push_sample(6'd63, 16'h8000, 1'b1, 1'b0);
        push_sample(6'd63, 16'h7fff, 1'b0, 1'b1);
        // three frames
        push_sample(6'd5, 16'h7fff, 1'b1, 1'b0);
        push_sample(6'd5, 16'h8000, 1'b0, 1'b0);
        push_sample(6'd5, 16'h7fff, 1'b0, 1'b1);
    endtask

    // no first mark, count starts from zero and saturates
    task automatic test_long_sequence();
        push_sample(6'd42, 16'h7fff, 1'b0, 1'b0);
        push_sample(6'd42, 16'h8000, 1'b0, 1'b0);
        push_sample(6'd42, 16'h7fff, 1'b0, 1'b0);
        push_sample(6'd42, 16'h8000, 1'b0, 1'b0);
        push_sample(6'd42, 16'h0000, 1'b0, 1'b0);
        push_sample(6'd42, 16'hffff, 1'b0, 1'b1);
    endtask

    // new first mark drops the unfinished sequence
    task automatic test_restart();
        push_sample(6'd21, 16'h1234, 1'b1, 1'b0);
        push_sample(6'd21, 16'hedcb, 1'b0, 1'b0);
        push_sample(6'd21, 16'h4000, 1'b0, 1'b0);
        push_sample(6'd21, 16'h8000, 1'b1, 1'b0);
        push_sample(6'd21, 16'h7fff, 1'b0, 1'b1);
    endtask

    // passthrough mode, and pending frames of another dim surviving it
    task automatic test_enable_toggle();
        push_sample(6'd7, 16'h7fff, 1'b1, 1'b0);
        push_sample(6'd7, 16'h0001, 1'b0, 1'b0);
        settle();
        write_enable(1'b0);
        push_sample(6'd56, 16'h8000, 1'b1, 1'b1);
        push_sample(6'd57, 16'h7fff, 1'b0, 1'b0);
        push_sample(6'd58, 16'hffff, 1'b1, 1'b0);
        settle();
        write_enable(1'b1);
        push_sample(6'd7, 16'h8000, 1'b0, 1'b1);
    endtask

    // interleaved well-formed sequences on four streams, with some noise
    task automatic test_random_streams(input int n_items);
        int         left [0:3];
        int         pos [0:3];
        logic [5:0] sdim [0:3];
        int         k;
        for (k = 0; k < 4; k++) begin
            left[k] = 0;
            pos[k]  = 0;
            sdim[k] = 6'(k);
        end
        for (int sent = 0; sent < n_items; sent++) begin
            k = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) begin
                push_sample(6'($urandom_range(0, 63)), rand_sample(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                if (left[k] == 0) begin
                    sdim[k] = 6'(($urandom_range(0, 15) << 2) | k);
                    left[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14)
                                                          : $urandom_range(1, 6);
                    pos[k]  = 0;
                end
                push_sample(sdim[k], rand_sample(),
                            pos[k] == 0 && $urandom_range(0, 7) != 0, left[k] == 1);
                pos[k]++;
                left[k]--;
            end
        end
    endtask

    task automatic test_passthrough_random(input int n_items);
        for (int i = 0; i < n_items; i++)
            push_sample(6'($urandom_range(0, 63)), rand_sample(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // sink holds off long while the source keeps offering
    task automatic test_backpressure(input int n_items);
        stall_asks++;
        test_random_streams(n_items);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int waited;
        dlt_en = 1'b1;
        for (int d = 0; d < N_DIMS; d++) begin
            cnt[d] = 0;
            for (int j = 0; j < HIST_DEPTH; j++) hist[d][j] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_frame();
        test_short_sequences();
        test_long_sequence();
        test_restart();
        test_enable_toggle();
        settle();

        test_random_streams(120);
        settle();
        write_enable(1'b0);
        test_passthrough_random(40);
        settle();
        write_enable(1'b1);
        test_backpressure(40);
        settle();

        no_idle = 1'b1;
        test_random_streams(60);
        s_tvalid <= 1'b0;

        // drain
        waited = 0;
        while (pending_feats.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge clk);
            waited++;
        end
        repeat (LAT_PAD) @(posedge clk);

        if (mism == 0 && pending_feats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_feats.size() != 0)
                $display("%0t %0d results never arrived", $time, pending_feats.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
